/* src/r2k_pkg.sv */
// shared types, codes and conversion functions for the romaji to kana stream
package r2k_pkg;

   localparam int MODE_W = 6;
   localparam int BYTE_W = 8;
   localparam int CNT_W = 2;

   typedef enum logic [MODE_W-1:0] {
      MD_NONE = 6'd0, MD_K = 6'd1, MD_S = 6'd2, MD_T = 6'd3, MD_N = 6'd4,
      MD_H = 6'd5, MD_F = 6'd6, MD_M = 6'd7, MD_Y = 6'd8, MD_R = 6'd9,
      MD_W = 6'd10, MD_L = 6'd11, MD_C = 6'd12, MD_G = 6'd13, MD_Z = 6'd14,
      MD_J = 6'd15, MD_D = 6'd16, MD_B = 6'd17, MD_P = 6'd18, MD_V = 6'd19,
      MD_KY = 6'd20, MD_SY = 6'd21, MD_SH = 6'd22, MD_TY = 6'd23,
      MD_CH = 6'd24, MD_TS = 6'd25, MD_NY = 6'd26, MD_HY = 6'd27,
      MD_FY = 6'd28, MD_MY = 6'd29, MD_RY = 6'd30, MD_GY = 6'd31,
      MD_ZY = 6'd32, MD_DY = 6'd33, MD_DH = 6'd34, MD_BY = 6'd35,
      MD_PY = 6'd36, MD_LY = 6'd37, MD_LT = 6'd38, MD_HW = 6'd39,
      MD_KW = 6'd40, MD_NW = 6'd41, MD_GW = 6'd42
   } mode_type;

   typedef enum logic [1:0] {
      CSR_HANKUL_WO = 2'd0,
      CSR_DI_AS_DHI = 2'd1
   } csr_index_type;

   localparam logic [7:0] KA_A = 8'hB1, KA_K = 8'hB6, KA_S = 8'hBB, KA_T = 8'hC0;
   localparam logic [7:0] KA_N = 8'hC5, KA_H = 8'hCA, KA_M = 8'hCF, KA_Y = 8'hD4;
   localparam logic [7:0] KA_R = 8'hD7, KA_W = 8'hDC, KA_WO = 8'hA6, KA_NN = 8'hDD;
   localparam logic [7:0] KA_VOICED = 8'hDE, KA_SEMI = 8'hDF, KA_SMALL = 8'hA7;
   localparam logic [7:0] KA_SMALLY = 8'hAC, KA_SMALLTSU = 8'hAF;

   // up to three bytes produced by one input item
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [BYTE_W-1:0] b0;
      logic [BYTE_W-1:0] b1;
      logic [BYTE_W-1:0] b2;
   } burst_type;

   typedef struct packed {
      logic hankul_wo;
      logic di_as_dhi;
   } cfg_type;

   function automatic logic [MODE_W-1:0] letter_code(input logic [4:0] i);
      logic [MODE_W-1:0] r;
      begin
         unique case (i)
            5'd0: r = 6'd0; 5'd1: r = MD_B; 5'd2: r = MD_C; 5'd3: r = MD_D;
            5'd4: r = 6'd3; 5'd5: r = MD_F; 5'd6: r = MD_G; 5'd7: r = MD_H;
            5'd8: r = 6'd1; 5'd9: r = MD_J; 5'd10: r = MD_K; 5'd11: r = MD_L;
            5'd12: r = MD_M; 5'd13: r = MD_N; 5'd14: r = 6'd4; 5'd15: r = MD_P;
            5'd16: r = MD_NONE; 5'd17: r = MD_R; 5'd18: r = MD_S; 5'd19: r = MD_T;
            5'd20: r = 6'd2; 5'd21: r = MD_V; 5'd22: r = MD_W; 5'd23: r = MD_L;
            5'd24: r = MD_Y; 5'd25: r = MD_Z;
            default: r = MD_NONE;
         endcase
         return r;
      end
   endfunction

   function automatic logic [7:0] base_of_mode(input logic [MODE_W-1:0] m);
      logic [7:0] r;
      begin
         unique case (m)
            MD_NONE, MD_V: r = KA_A;
            MD_K, MD_G, MD_KY, MD_GY, MD_KW, MD_GW: r = KA_K;
            MD_S, MD_C, MD_Z, MD_J, MD_SY, MD_SH, MD_ZY: r = KA_S;
            MD_T, MD_D, MD_TY, MD_CH, MD_TS, MD_DY, MD_DH: r = KA_T;
            MD_N, MD_NY, MD_NW: r = KA_N;
            MD_H, MD_F, MD_B, MD_P, MD_HY, MD_FY, MD_BY, MD_PY, MD_HW: r = KA_H;
            MD_M, MD_MY: r = KA_M;
            MD_Y: r = KA_Y;
            MD_R, MD_RY: r = KA_R;
            MD_W: r = KA_W;
            MD_L: r = KA_SMALL;
            MD_LY: r = KA_SMALLY;
            MD_LT: r = KA_SMALLTSU;
            default: r = KA_A;
         endcase
         return r;
      end
   endfunction

   function automatic logic [MODE_W-1:0] y_next(input logic [MODE_W-1:0] m);
      logic [MODE_W-1:0] r;
      begin
         unique case (m)
            MD_K: r = MD_KY; MD_S: r = MD_SY; MD_T, MD_C: r = MD_TY;
            MD_N: r = MD_NY; MD_H: r = MD_HY; MD_F: r = MD_FY; MD_M: r = MD_MY;
            MD_R: r = MD_RY; MD_L: r = MD_LY; MD_G: r = MD_GY;
            MD_Z, MD_J: r = MD_ZY; MD_D: r = MD_DY; MD_B: r = MD_BY;
            MD_P: r = MD_PY;
            default: r = MD_NONE;
         endcase
         return r;
      end
   endfunction

   function automatic logic [MODE_W-1:0] w_next(input logic [MODE_W-1:0] m);
      logic [MODE_W-1:0] r;
      begin
         unique case (m)
            MD_K: r = MD_KW; MD_N: r = MD_NW; MD_H: r = MD_HW; MD_G: r = MD_GW;
            default: r = MD_NONE;
         endcase
         return r;
      end
   endfunction

   function automatic logic [7:0] small_y(input logic [MODE_W-1:0] v);
      logic [7:0] r;
      begin
         unique case (v)
            6'd0: r = KA_SMALLY;
            6'd1: r = KA_SMALL + 8'd1;
            6'd2: r = KA_SMALLY + 8'd1;
            6'd3: r = KA_SMALL + 8'd3;
            6'd4: r = KA_SMALLY + 8'd2;
            default: r = 8'd0;
         endcase
         return r;
      end
   endfunction

   function automatic logic is_voiced(input logic [MODE_W-1:0] m);
      return (m >= MD_G && m <= MD_B) || m == MD_V ||
             (m >= MD_GY && m <= MD_BY) || m == MD_GW;
   endfunction

   function automatic burst_type push(input burst_type s, input logic [7:0] v);
      burst_type r;
      begin
         r = s;
         unique case (s.count)
            2'd0: r.b0 = v;
            2'd1: r.b1 = v;
            2'd2: r.b2 = v;
            default: r.b2 = s.b2;
         endcase
         if (s.count != 2'd3) r.count = s.count + 2'd1;
         return r;
      end
   endfunction

endpackage

/* src/romaji_to_kana_stream.sv */
// top level of the romaji to half-width katakana stream converter
//
// req channel: one beat per source byte; tlast marks end of text
// rsp channel: one beat per output byte; tlast marks the final byte of an item
// csr port: write-only, index 0 hankul_wo, index 1 di_as_dhi
// an item that yields no byte (e.g. a lone consonant) gives no rsp beat
// an item's first byte passes through the front register and then the burst queue before it reaches rsp
// throughput: one req beat per cycle while the queue has room; rsp moves
//   one byte per cycle while rsp_tready is high, so an item holds the back end until its last byte goes
// a two-entry burst queue at the head of the back end absorbs rsp stalls;
//   when it and the front register are full, req_tready drops
// reset clears pending mode, trail byte flag, queue and config bits
// no byte is lost or repeated under any stall pattern
module romaji_to_kana_stream
   import r2k_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,   // last
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [0:0]  csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   burst_type burst;
   logic      burst_valid, burst_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case ({1'b0, csr_index})
            CSR_HANKUL_WO: cfg_in.hankul_wo = csr_wdata[0];
            CSR_DI_AS_DHI: cfg_in.di_as_dhi = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '0;
      else cfg_ff <= cfg_in;
   end

   r2k_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_byte     (req_tdata),
      .in_end      (req_tlast),
      .burst_valid (burst_valid),
      .burst_ready (burst_ready),
      .burst       (burst)
   );

   r2k_back u_back (
      .clock       (clock),
      .reset       (reset),
      .burst_valid (burst_valid),
      .burst_ready (burst_ready),
      .burst       (burst),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_byte    (rsp_tdata),
      .out_last    (rsp_tlast)
   );

endmodule

/* src/r2k_front.sv */
// front end: classifies each byte, tracks pending mode, produces a kana burst
module r2k_front
   import r2k_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [7:0]       in_byte,
   input  logic             in_end,
   output logic             burst_valid,
   input  logic             burst_ready,
   output burst_type        burst
);

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              trail_ff, trail_in;
   logic              valid_ff, valid_in;
   burst_type         burst_ff, burst_in;
   burst_type         calc;
   logic              fire;

   assign in_ready    = !valid_ff || burst_ready;
   assign fire        = in_valid && in_ready;
   assign burst_valid = valid_ff;
   assign burst       = burst_ff;

   always_comb begin
      logic [7:0]        b, c, base;
      logic [MODE_W-1:0] m, idx, nx;
      logic              v, done;
      calc     = '0;
      mode_in  = mode_ff;
      trail_in = trail_ff;
      b        = in_byte;
      c        = 8'd0;
      m        = MD_NONE;
      idx      = MD_NONE;
      nx       = MD_NONE;
      base     = '0;
      v        = 1'b0;
      done     = 1'b0;
      if (in_end) begin
         if (mode_ff == MD_N) calc = push(calc, KA_NN);
         calc     = push(calc, 8'd0);
         mode_in  = MD_NONE;
         trail_in = 1'b0;
      end else if (trail_ff) begin
         calc     = push(calc, b);
         trail_in = 1'b0;
      end else if ((b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC)) begin
         calc     = push(calc, b);
         trail_in = 1'b1;
      end else if (!((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A))) begin
         priority case (b)
            8'h2E: b = 8'hA1;
            8'h5B: b = 8'hA2;
            8'h5D: b = 8'hA3;
            8'h2C: b = 8'hA4;
            8'h2F: b = 8'hA5;
            default: b = b;
         endcase
         if (mode_ff == MD_N) begin
            calc = push(calc, KA_NN);
            if (b != 8'h27 && b != 8'h20) calc = push(calc, b);
         end else begin
            calc = push(calc, b);
         end
         mode_in = MD_NONE;
      end else begin
         c    = (b <= 8'h5A) ? b + 8'h20 : b;
         m    = (mode_ff < 6'd43) ? mode_ff : MD_NONE;
         idx  = letter_code(5'(c - 8'h61));
         v    = (c == "a") || (c == "i") || (c == "u") || (c == "e") || (c == "o");
         if (m != MD_NONE && m < 6'd19 && c == "y") begin
            nx = y_next(m);
            idx = nx;
            if (nx != MD_NONE) begin mode_in = nx; done = 1'b1; end
         end else if (m != MD_NONE && m < 6'd14 && c == "w") begin
            nx = w_next(m);
            idx = nx;
            if (nx != MD_NONE) begin mode_in = nx; done = 1'b1; end
         end
         if (!done) begin
            if (m == MD_T && c == "c") m = MD_C;
            if (!v && idx == m && m != MD_N && m != MD_M && m != MD_NONE) begin
               mode_in = m;
               calc = push(calc, KA_SMALLTSU);
               done = 1'b1;
            end else if (m == MD_M && (idx == MD_M || idx == MD_B || idx == MD_P)) begin
               calc = push(calc, KA_NN);
               mode_in = idx;
               done = 1'b1;
            end else if (cfg.di_as_dhi && m == MD_D && c == "i") begin
               m = MD_DH;
            end
         end
         if (!done) begin
            base = base_of_mode(m);
            unique case (m)
               MD_NONE, MD_L, MD_S, MD_T: begin
                  if (v) calc = push(calc, base + 8'(idx));
                  else if (m == MD_L && c == "t") m = MD_LT;
                  else if (m == MD_S && c == "h") m = MD_SH;
                  else if (m == MD_T && c == "s") m = MD_TS;
                  else m = idx;
               end
               MD_N: begin
                  if (v) calc = push(calc, base + 8'(idx));
                  else if (c == "n") begin calc = push(calc, KA_NN); m = MD_NONE; end
                  else begin calc = push(calc, KA_NN); m = idx; end
               end
               MD_B, MD_G, MD_K, MD_M, MD_P, MD_R, MD_Z, MD_D: begin
                  if (v) begin
                     calc = push(calc, base + 8'(idx));
                     if (is_voiced(m)) calc = push(calc, KA_VOICED);
                     else if (m == MD_P) calc = push(calc, KA_SEMI);
                  end else if (m == MD_D && c == "h") m = MD_DH;
                  else m = idx;
               end
               MD_H: begin
                  if (v) calc = push(calc, base + 8'(idx));
                  else begin calc = push(calc, KA_A + 8'd2); m = idx; end
               end
               MD_C, MD_LT: begin
                  if (m == MD_C && c == "h") m = MD_CH;
                  else if (m == MD_LT && c == "u") calc = push(calc, KA_SMALLTSU);
                  else m = idx;
               end
               MD_F, MD_V, MD_TS: begin
                  if (v) begin
                     calc = push(calc, base + 8'd2);
                     if (is_voiced(m)) calc = push(calc, KA_VOICED);
                     if (c != "u") calc = push(calc, KA_SMALL + 8'(idx));
                  end else m = idx;
               end
               MD_W: begin
                  if (c == "a") calc = push(calc, KA_W);
                  else if (c == "i" || c == "e") begin
                     calc = push(calc, KA_A + 8'd2);
                     calc = push(calc, KA_SMALL + 8'(idx));
                  end else if (c == "u") calc = push(calc, KA_A + 8'd2);
                  else if (c == "o") begin
                     if (cfg.hankul_wo) begin
                        calc = push(calc, KA_A + 8'd2);
                        calc = push(calc, KA_SMALL + 8'd4);
                     end else calc = push(calc, KA_WO);
                  end else m = idx;
               end
               MD_Y: begin
                  if (c == "a") calc = push(calc, KA_Y);
                  else if (c == "i") calc = push(calc, KA_A + 8'd1);
                  else if (c == "u") calc = push(calc, KA_Y + 8'd1);
                  else if (c == "e") begin
                     calc = push(calc, KA_A + 8'd1);
                     calc = push(calc, KA_SMALL + 8'd3);
                  end else if (c == "o") calc = push(calc, KA_Y + 8'd2);
                  else m = idx;
               end
               MD_KY, MD_SY, MD_TY, MD_NY, MD_HY, MD_MY,
               MD_RY, MD_GY, MD_ZY, MD_DY, MD_BY, MD_PY: begin
                  if (v) begin
                     calc = push(calc, base + 8'd1);
                     if (m == MD_PY) calc = push(calc, KA_SEMI);
                     else if (is_voiced(m)) calc = push(calc, KA_VOICED);
                     calc = push(calc, small_y(idx));
                  end else m = idx;
               end
               MD_J, MD_SH, MD_CH: begin
                  if (v) begin
                     calc = push(calc, base + 8'd1);
                     if (is_voiced(m)) calc = push(calc, KA_VOICED);
                     if (c != "i") calc = push(calc, small_y(idx));
                  end else m = idx;
               end
               MD_FY: begin
                  if (v) begin
                     calc = push(calc, base + 8'd2);
                     calc = push(calc, small_y(idx));
                  end else m = idx;
               end
               MD_LY: begin
                  if (v) calc = push(calc, small_y(idx));
                  else m = idx;
               end
               MD_DH: begin
                  if (v) begin
                     calc = push(calc, base + 8'd3);
                     calc = push(calc, KA_VOICED);
                     calc = push(calc, small_y(idx));
                  end else m = idx;
               end
               MD_GW, MD_HW, MD_KW, MD_NW: begin
                  if (v) begin
                     calc = push(calc, base + 8'd2);
                     if (is_voiced(m)) calc = push(calc, KA_VOICED);
                     calc = push(calc, KA_SMALL + 8'(idx));
                  end else m = idx;
               end
               default: m = m;
            endcase
            if (v) m = MD_NONE;
            mode_in = m;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      burst_in = burst_ff;
      if (fire) begin
         valid_in = calc.count != 2'd0;
         burst_in = calc;
      end else if (burst_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MD_NONE;
         trail_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            mode_ff  <= mode_in;
            trail_ff <= trail_in;
         end
         valid_ff <= valid_in;
      end
      burst_ff <= burst_in;
   end

`ifndef SYNTHESIS
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> burst_ff.count != 2'd0)
      else $error("empty burst");
   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      mode_ff < 6'd43) else $error("pending mode out of range");
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      fire && in_end |=> mode_ff == MD_NONE && !trail_ff)
      else $error("end of text left state behind");
`endif

endmodule

/* src/r2k_back.sv */
// back end: two-entry burst queue and byte serializer with last flag
module r2k_back
   import r2k_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        burst_valid,
   output logic        burst_ready,
   input  burst_type   burst,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [7:0]  out_byte,
   output logic        out_last
);

   burst_type   q_ff [2];
   burst_type   q_in [2];
   logic [1:0]  fill_ff, fill_in;
   logic [1:0]  pos_ff, pos_in;
   logic        push_en, pop_en, beat;

   assign burst_ready = fill_ff != 2'd2;
   assign push_en     = burst_valid && burst_ready;
   assign out_valid   = fill_ff != 2'd0;
   assign beat        = out_valid && out_ready;
   assign out_last    = (pos_ff + 2'd1) == q_ff[0].count;
   assign pop_en      = beat && out_last;

   always_comb begin
      unique case (pos_ff)
         2'd0: out_byte = q_ff[0].b0;
         2'd1: out_byte = q_ff[0].b1;
         default: out_byte = q_ff[0].b2;
      endcase
   end

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      fill_in = fill_ff;
      pos_in  = pos_ff;
      if (beat) pos_in = pop_en ? 2'd0 : pos_ff + 2'd1;
      if (pop_en) begin
         q_in[0] = q_ff[1];
         fill_in = fill_ff - 2'd1;
      end
      if (push_en) begin
         if (fill_in == 2'd0) q_in[0] = burst;
         else q_in[1] = burst;
         fill_in = fill_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
         pos_ff  <= 2'd0;
      end else begin
         fill_ff <= fill_in;
         pos_ff  <= pos_in;
      end
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3) else $error("queue overflow");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> pos_ff < q_ff[0].count) else $error("byte index past burst");
   a_idle_pos: assert property (@(posedge clock) disable iff (reset)
      fill_ff == 2'd0 |-> pos_ff == 2'd0) else $error("stale byte index");
`endif

endmodule
